// ----- hdl/euler_to_quaternion_macros.svh -----
// assertion helpers for the euler_to_quaternion checker
`ifndef EULER_TO_QUATERNION_MACROS_SVH
`define EULER_TO_QUATERNION_MACROS_SVH

// expression must hold at every clock edge outside reset
`define EQ_ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("assertion failed");

// consequent must hold whenever the antecedent holds
`define EQ_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

// ----- hdl/eq_pkg.sv -----
package eq_pkg;

    // input item: three binary angles, 65536 per turn
    typedef struct packed {
        logic signed [15:0] heading;
        logic signed [15:0] pitch;
        logic signed [15:0] bank;
    } t_angles;

    // result item: quaternion in signed Q2.14
    typedef struct packed {
        logic signed [15:0] quat_w;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
    } t_quat;

    // sine and cosine of a half angle, Q20
    typedef struct packed {
        logic signed [21:0] s;
        logic signed [21:0] c;
    } t_sc;

    typedef logic [30:0] t_q30;
    typedef logic signed [32:0] t_comp;
    typedef t_comp [3:0] t_comp_vec;

    // registers from an accepted item to its result strobe
    localparam int PIPE_DEPTH = 65;

    localparam logic signed [15:0] Q14_ONE = 16'sd16384;

    // taylor coefficients of sin(t*pi/2) and cos(t*pi/2), Q30
    localparam t_q30 SIN_C [5] = '{
        31'd1686629713, 31'd693598668, 31'd85569305, 31'd5026995, 31'd172272
    };
    localparam t_q30 COS_C [6] = '{
        31'd1073741824, 31'd1324675879, 31'd272375560, 31'd22401990,
        31'd987048, 31'd27060
    };

    // subtraction that stops at zero
    function automatic t_q30 sub_clamp(t_q30 x, logic [31:0] y);
        logic [31:0] xe;
        xe = {1'b0, x};
        return (xe > y) ? t_q30'(xe - y) : '0;
    endfunction

endpackage

// ----- hdl/eq_sincos.sv -----
module eq_sincos import eq_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic signed [15:0] i_angle,
    output logic               o_valid,
    output t_sc                o_sc
);

    localparam int STEPS = 5;

    logic [STEPS:0]  r_vld;
    logic [15:0]     r_m   [0:STEPS-1];
    t_q30            r_u   [0:STEPS-1];
    logic            r_neg [0:STEPS];
    t_q30            r_sp  [1:STEPS];
    t_q30            r_cp  [1:STEPS];
    logic            r_vo;
    t_sc             r_sc;

    logic [16:0] w_ext;
    logic [16:0] w_abs;
    logic [31:0] w_sq;
    logic [21:0] w_s;
    logic [21:0] w_c;

    // magnitude of the angle and u = t*t in Q30
    assign w_ext = {i_angle[15], i_angle};
    assign w_abs = i_angle[15] ? (17'd0 - w_ext) : w_ext;
    assign w_sq  = w_abs[15:0] * w_abs[15:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_valid;
        end
        r_m[0]   <= w_abs[15:0];
        r_u[0]   <= t_q30'(w_sq);
        r_neg[0] <= i_angle[15];
    end

    // one horner step of both polynomials per stage
    genvar k;
    for (k = 1; k <= STEPS; k++) begin : g_step
        t_q30        w_cin;
        t_q30        w_sin;
        logic [61:0] w_cprod;
        logic [61:0] w_sprod;

        if (k == 1) begin : g_first
            assign w_cin = COS_C[STEPS];
            assign w_sin = SIN_C[STEPS-1];
        end else begin : g_next
            assign w_cin = r_cp[k-1];
            assign w_sin = r_sp[k-1];
        end

        assign w_cprod = w_cin * r_u[k-1];

        if (k < STEPS) begin : g_horner
            assign w_sprod = w_sin * r_u[k-1];
            always_ff @(posedge i_clk) begin
                r_sp[k] <= sub_clamp(SIN_C[STEPS-1-k], w_sprod[61:30]);
                r_u[k]  <= r_u[k-1];
                r_m[k]  <= r_m[k-1];
            end
        end else begin : g_odd
            // last sine step multiplies by t = m << 15
            assign w_sprod = w_sin * {r_m[k-1], 15'b0};
            always_ff @(posedge i_clk) begin
                r_sp[k] <= t_q30'(w_sprod[61:30]);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= r_vld[k-1];
            end
            r_cp[k]  <= sub_clamp(COS_C[STEPS-k], w_cprod[61:30]);
            r_neg[k] <= r_neg[k-1];
        end
    end

    // drop to Q20 and apply the sine sign
    assign w_s = {1'b0, r_sp[STEPS][30:10]};
    assign w_c = {1'b0, r_cp[STEPS][30:10]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vo <= 1'b0;
        end else begin
            r_vo <= r_vld[STEPS];
        end
        r_sc.s <= r_neg[STEPS] ? $signed(22'd0 - w_s) : $signed(w_s);
        r_sc.c <= $signed(w_c);
    end

    assign o_valid = r_vo;
    assign o_sc    = r_sc;

endmodule

// ----- hdl/eq_prod.sv -----
module eq_prod import eq_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_sc       i_h,
    input  t_sc       i_p,
    input  t_sc       i_b,
    output logic      o_valid,
    output t_comp_vec o_q
);

    // product j uses pair PI[j] and the bank sine when USE_SB[j] is set
    // order: w1 w2 x1 x2 y1 y2 z1 z2
    localparam int PI [8] = '{0, 1, 2, 3, 3, 2, 0, 1};
    localparam logic [7:0] USE_SB = 8'b0110_1010;

    logic [3:0]         r_v;
    logic signed [43:0] r_pair [4];
    t_sc                r_b;
    logic signed [43:0] r_hi   [8];
    logic signed [44:0] r_lo   [8];
    logic signed [65:0] r_prod [8];
    t_comp_vec          r_q;

    logic signed [43:0] w_hi [8];
    logic signed [44:0] w_lo [8];
    logic signed [66:0] w_sum [4];

    // heading-pitch pair products
    always_ff @(posedge i_clk) begin
        r_pair[0] <= i_h.c * i_p.c;
        r_pair[1] <= i_h.s * i_p.s;
        r_pair[2] <= i_h.c * i_p.s;
        r_pair[3] <= i_h.s * i_p.c;
        r_b       <= i_b;
    end

    // times bank, pair split into high and low halves
    always_comb begin
        for (int j = 0; j < 8; j++) begin
            w_hi[j] = $signed(r_pair[PI[j]][43:22]) * (USE_SB[j] ? r_b.s : r_b.c);
            w_lo[j] = $signed({1'b0, r_pair[PI[j]][21:0]})
                      * (USE_SB[j] ? r_b.s : r_b.c);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < 8; j++) begin
            r_hi[j]   <= w_hi[j];
            r_lo[j]   <= w_lo[j];
            r_prod[j] <= (66'(r_hi[j]) <<< 22) + 66'(r_lo[j]);
        end
    end

    // component sums, floored to Q30
    always_comb begin
        w_sum[3] = 67'(r_prod[0]) + 67'(r_prod[1]);
        w_sum[2] = 67'(r_prod[2]) + 67'(r_prod[3]);
        w_sum[1] = 67'(r_prod[4]) - 67'(r_prod[5]);
        w_sum[0] = 67'(r_prod[6]) - 67'(r_prod[7]);
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 4; i++) begin
            r_q[i] <= $signed(w_sum[i][62:30]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[2:0], i_valid};
        end
    end

    assign o_valid = r_v[3];
    assign o_q     = r_q;

endmodule

// ----- hdl/eq_sqrt.sv -----
module eq_sqrt import eq_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_comp_vec   i_q,
    output logic        o_valid,
    output t_comp_vec   o_q,
    output logic [31:0] o_mag
);

    localparam int ROOT_STEPS = 32;

    logic [63:0]         r_sq  [4];
    logic [63:0]         r_s01;
    logic [63:0]         r_s23;
    logic [63:0]         r_n   [0:ROOT_STEPS];
    logic [63:0]         r_r   [0:ROOT_STEPS];
    t_comp_vec           r_qa;
    t_comp_vec           r_qb;
    t_comp_vec           r_qs  [0:ROOT_STEPS];
    logic                r_va;
    logic                r_vb;
    logic [ROOT_STEPS:0] r_vs;

    logic [32:0] w_m  [4];
    logic [65:0] w_sq [4];

    // squares of the component magnitudes
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            w_m[i]  = i_q[i][32] ? (33'd0 - i_q[i]) : i_q[i];
            w_sq[i] = w_m[i] * w_m[i];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 4; i++) begin
            r_sq[i] <= w_sq[i][63:0];
        end
        r_qa  <= i_q;
        r_s01 <= r_sq[0] + r_sq[1];
        r_s23 <= r_sq[2] + r_sq[3];
        r_qb  <= r_qa;
        r_n[0]  <= r_s01 + r_s23;
        r_r[0]  <= '0;
        r_qs[0] <= r_qb;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va    <= 1'b0;
            r_vb    <= 1'b0;
            r_vs[0] <= 1'b0;
        end else begin
            r_va    <= i_valid;
            r_vb    <= r_va;
            r_vs[0] <= r_vb;
        end
    end

    // one result bit of the integer square root per stage
    genvar k;
    for (k = 0; k < ROOT_STEPS; k++) begin : g_root
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
        logic [63:0] w_trial;

        assign w_trial = r_r[k] + BIT;

        always_ff @(posedge i_clk) begin
            if (r_n[k] >= w_trial) begin
                r_n[k+1] <= r_n[k] - w_trial;
                r_r[k+1] <= (r_r[k] >> 1) + BIT;
            end else begin
                r_n[k+1] <= r_n[k];
                r_r[k+1] <= r_r[k] >> 1;
            end
            r_qs[k+1] <= r_qs[k];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vs[k+1] <= 1'b0;
            end else begin
                r_vs[k+1] <= r_vs[k];
            end
        end
    end

    assign o_valid = r_vs[ROOT_STEPS];
    assign o_q     = r_qs[ROOT_STEPS];
    assign o_mag   = r_r[ROOT_STEPS][31:0];

endmodule

// ----- hdl/eq_norm.sv -----
module eq_norm import eq_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_comp_vec   i_q,
    input  logic [31:0] i_mag,
    output logic        o_valid,
    output t_quat       o_quat
);

    localparam int QBITS = 16;
    localparam int LAST  = QBITS + 1;

    logic [47:0]      r_rem  [0:LAST][4];
    logic [QBITS-1:0] r_quo  [2:LAST][4];
    logic [3:0]       r_neg  [0:LAST];
    logic [3:0]       r_ovf  [1:LAST];
    logic             r_zero [0:LAST];
    logic [31:0]      r_dv   [0:QBITS];
    logic [LAST:0]    r_v;
    logic             r_vo;
    t_quat            r_quat;

    logic [32:0] w_m [4];

    // rounded numerator |c| * 2^14 + mag / 2
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            w_m[i] = i_q[i][32] ? (33'd0 - i_q[i]) : i_q[i];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 4; i++) begin
            r_rem[0][i] <= 48'({w_m[i], 14'b0}) + 48'(i_mag[31:1]);
            r_neg[0][i] <= i_q[i][32];
        end
        r_zero[0] <= (i_mag == '0);
        r_dv[0]   <= i_mag;
    end

    // quotient too large for sixteen bits
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 4; i++) begin
            r_rem[1][i] <= r_rem[0][i];
            r_ovf[1][i] <= (r_rem[0][i] >= {r_dv[0], 16'b0});
        end
        r_neg[1]  <= r_neg[0];
        r_zero[1] <= r_zero[0];
        r_dv[1]   <= r_dv[0];
    end

    // restoring division, one quotient bit per stage from the top
    genvar j;
    for (j = 0; j < QBITS; j++) begin : g_div
        localparam int SH = QBITS - 1 - j;
        logic [47:0]      w_d;
        logic [QBITS-1:0] w_qin [4];

        assign w_d = 48'(r_dv[j+1]) << SH;

        if (j == 0) begin : g_first
            always_comb begin
                for (int i = 0; i < 4; i++) begin
                    w_qin[i] = '0;
                end
            end
        end else begin : g_next
            always_comb begin
                for (int i = 0; i < 4; i++) begin
                    w_qin[i] = r_quo[j+1][i];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            for (int i = 0; i < 4; i++) begin
                if (r_rem[j+1][i] >= w_d) begin
                    r_rem[j+2][i] <= r_rem[j+1][i] - w_d;
                    r_quo[j+2][i] <= w_qin[i] | (QBITS'(1) << SH);
                end else begin
                    r_rem[j+2][i] <= r_rem[j+1][i];
                    r_quo[j+2][i] <= w_qin[i];
                end
            end
            r_neg[j+2]  <= r_neg[j+1];
            r_ovf[j+2]  <= r_ovf[j+1];
            r_zero[j+2] <= r_zero[j+1];
        end

        if (j < QBITS - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                r_dv[j+2] <= r_dv[j+1];
            end
        end
    end

    // saturate, sign and zero-magnitude override
    function automatic logic signed [15:0] finish(logic [QBITS-1:0] quo, logic ovf,
                                                  logic neg, logic zero);
        logic [15:0] sat;
        sat = (ovf || quo > Q14_ONE) ? Q14_ONE : quo;
        if (zero) begin
            return '0;
        end
        return neg ? $signed(16'd0 - sat) : $signed(sat);
    endfunction

    always_ff @(posedge i_clk) begin
        r_quat.quat_w <= finish(r_quo[LAST][3], r_ovf[LAST][3], r_neg[LAST][3], r_zero[LAST]);
        r_quat.quat_x <= finish(r_quo[LAST][2], r_ovf[LAST][2], r_neg[LAST][2], r_zero[LAST]);
        r_quat.quat_y <= finish(r_quo[LAST][1], r_ovf[LAST][1], r_neg[LAST][1], r_zero[LAST]);
        r_quat.quat_z <= finish(r_quo[LAST][0], r_ovf[LAST][0], r_neg[LAST][0], r_zero[LAST]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v  <= '0;
            r_vo <= 1'b0;
        end else begin
            r_v  <= {r_v[LAST-1:0], i_valid};
            r_vo <= r_v[LAST];
        end
    end

    assign o_valid = r_vo;
    assign o_quat  = r_quat;

endmodule

// ----- hdl/euler_to_quaternion.sv -----
// heading, pitch and bank to a normalized quaternion
//
// input: i_angles holds three 16-bit binary angles, 65536 to a full turn.
// an item is taken at a rising edge where start is high and busy is low.
// busy stays low, so a new item can be taken at every clock edge.
//
// output: o_quat holds w, x, y, z in signed Q2.14, clamped to +-1.0.
// o_done is high for exactly one cycle per item; the result must be
// taken in that cycle, the receiver cannot hold it off.
//
// pipeline: o_done follows the accepting edge through 65 register
// stages: 7 for the half-angle sine and cosine polynomials, 4 for the
// triple products, 35 for the squared magnitude and its one-bit-per-stage
// square root, 19 for the one-bit-per-stage divider.
// throughput: one item per cycle, results leave in the order items came.
//
// reset: synchronous, active low, clears the valid bits of every stage;
// items in flight are dropped and no strobe follows until new items pass.
module euler_to_quaternion import eq_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  t_angles i_angles,
    output logic    busy,
    output logic    o_done,
    output t_quat   o_quat
);

    logic      w_acc;
    logic      w_vh, w_vp, w_vb;
    t_sc       w_sh, w_sp, w_sb;
    logic      w_vq;
    t_comp_vec w_q;
    logic      w_vm;
    t_comp_vec w_qm;
    logic [31:0] w_mag;

    // the pipeline takes an item every cycle
    assign busy  = 1'b0;
    assign w_acc = start & ~busy;

    // half-angle sine and cosine per angle
    eq_sincos u_sc_heading (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_acc),
        .i_angle (i_angles.heading),
        .o_valid (w_vh),
        .o_sc    (w_sh)
    );

    eq_sincos u_sc_pitch (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_acc),
        .i_angle (i_angles.pitch),
        .o_valid (w_vp),
        .o_sc    (w_sp)
    );

    eq_sincos u_sc_bank (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_acc),
        .i_angle (i_angles.bank),
        .o_valid (w_vb),
        .o_sc    (w_sb)
    );

    // quaternion components
    eq_prod u_prod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_vh & w_vp & w_vb),
        .i_h     (w_sh),
        .i_p     (w_sp),
        .i_b     (w_sb),
        .o_valid (w_vq),
        .o_q     (w_q)
    );

    // magnitude
    eq_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_vq),
        .i_q     (w_q),
        .o_valid (w_vm),
        .o_q     (w_qm),
        .o_mag   (w_mag)
    );

    // normalize to Q2.14
    eq_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_vm),
        .i_q     (w_qm),
        .i_mag   (w_mag),
        .o_valid (o_done),
        .o_quat  (o_quat)
    );

endmodule

// ----- hdl/eq_checker.sv -----
`include "euler_to_quaternion_macros.svh"

module eq_checker import eq_pkg::*; (
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    start,
    input t_angles i_angles,
    input logic    busy,
    input logic    o_done,
    input t_quat   o_quat
);

    logic w_in_range;
    logic w_is_identity;

    // every component within plus or minus one
    assign w_in_range = o_quat.quat_w <= Q14_ONE && o_quat.quat_w >= -Q14_ONE
                     && o_quat.quat_x <= Q14_ONE && o_quat.quat_x >= -Q14_ONE
                     && o_quat.quat_y <= Q14_ONE && o_quat.quat_y >= -Q14_ONE
                     && o_quat.quat_z <= Q14_ONE && o_quat.quat_z >= -Q14_ONE;

    // unit scalar part, zero vector part
    assign w_is_identity = o_quat.quat_w == Q14_ONE && o_quat.quat_x == '0
                        && o_quat.quat_y == '0 && o_quat.quat_z == '0;

    // every result goes back to an item taken a fixed time before
    `EQ_ASSERT_IMPLIES(a_done_has_item, o_done, $past(start && !busy, PIPE_DEPTH))

    // all components stay within one
    `EQ_ASSERT_IMPLIES(a_unit_range, o_done, w_in_range)

    // zero angles give the identity rotation
    `EQ_ASSERT_IMPLIES(a_identity, o_done && $past(start && i_angles == '0, PIPE_DEPTH), w_is_identity)

    // the pipeline never refuses an item
    `EQ_ASSERT_ALWAYS(a_never_busy, !busy)

endmodule

bind euler_to_quaternion eq_checker u_eq_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .i_angles (i_angles),
    .busy     (busy),
    .o_done   (o_done),
    .o_quat   (o_quat)
);
